/* hw/rtl/rcfv_pkg.sv */
// Shared constants, codes and item types for the Rhie-Chow face velocity unit.
package rcfv_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int SPC_BITS  = 32;
    localparam int AXIS_BITS = 2;
    localparam int FLAG_BITS = 4;
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    localparam logic [SPC_BITS-1:0] INV_RESET = SPC_BITS'(1) << FRAC_BITS;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_INV_X = 2'd0;
    localparam logic [1:0] REG_INV_Y = 2'd1;
    localparam logic [1:0] REG_INV_Z = 2'd2;

    // axis codes; any other code selects z
    localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;

    // fluid flag bit positions
    localparam int FLG_BEHIND = 0;
    localparam int FLG_HERE   = 1;
    localparam int FLG_NEXT   = 2;
    localparam int FLG_BEYOND = 3;

    typedef struct packed {
        logic [AXIS_BITS-1:0]        axis;
        logic signed [WORD_BITS-1:0] vel_here;
        logic signed [WORD_BITS-1:0] vel_next;
        logic signed [WORD_BITS-1:0] coef_here;
        logic signed [WORD_BITS-1:0] coef_next;
        logic signed [WORD_BITS-1:0] pres_behind;
        logic signed [WORD_BITS-1:0] pres_here;
        logic signed [WORD_BITS-1:0] pres_next;
        logic signed [WORD_BITS-1:0] pres_beyond;
        logic [FLAG_BITS-1:0]        fluid_flags;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] face_velocity;
        logic                        blocked;
        logic                        saturated;
    } t_out_item;

endpackage

/* hw/rtl/rhie_chow_face_velocity_unit.sv */
// Rhie-Chow face velocity unit: pipelined reciprocal, correction product and output clip.
// Throughput: one item per cycle while the result channel is not stalled;
// the bit-per-stage divider and the chunked correction multiplier are fully
// pipelined, and stalls only close empty slots.
// Reset (synchronous, active low) empties the pipeline and sets all three
// spacing registers to 1.0.
module rhie_chow_face_velocity_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rcfv_pkg::t_in_item            i_in_item,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rcfv_pkg::t_out_item           o_out_item,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcfv_pkg::ADDR_BITS-1:0] paddr,
    input  logic [rcfv_pkg::DATA_BITS-1:0] pwdata,
    output logic [rcfv_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);
    import rcfv_pkg::*;

    localparam int W      = WORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int QB     = W - 1;          // quotient bits of the reciprocal
    localparam int SW     = W + 1;          // pair sums
    localparam int PSW    = W + 5;          // combined pressure term, signed
    localparam int MW     = W + 4;          // its magnitude
    localparam int DIV_SH = 2 * F + 1;
    localparam int SAT_EXP = (DIV_SH >= W - 1) ? (DIV_SH - (W - 1)) : 0;
    // reciprocal clips when the coefficient sum is at or below this
    localparam logic [63:0] SAT_LIM = (DIV_SH >= W - 1) ? (64'd1 << SAT_EXP) : 64'd0;
    localparam logic [W-1:0] R0_VAL = W'(SAT_LIM);
    localparam int DLO    = (QB + 1) / 2;
    localparam int DHI    = QB - DLO;
    localparam int PW1    = QB + SPC_BITS;
    localparam int CK     = 27;
    localparam int NA     = (PW1 + CK - 1) / CK;
    localparam int NB     = (MW + CK - 1) / CK;
    localparam int ROWW   = NB * CK + CK;
    localparam int PW     = NA * CK + NB * CK;
    localparam int VW     = PW - DIV_SH;
    localparam int CW     = W + 3;          // capped correction magnitude
    localparam int RW     = W + 5;          // doubled result
    localparam logic [VW-1:0] CAP = VW'(1) << (W + 2);
    localparam logic [QB-1:0] D_MAX = '1;

    // pipeline slots
    localparam int ST_S0  = 0;
    localparam int ST_DV0 = 1;
    localparam int ST_M1  = QB + 2;
    localparam int ST_M2  = QB + 3;
    localparam int ST_M3  = QB + 4;
    localparam int ST_M4  = QB + 5;
    localparam int ST_M5  = QB + 6;
    localparam int ST_M6  = QB + 7;
    localparam int ST_OUT = QB + 8;
    localparam int NST    = QB + 9;

    typedef struct packed {
        logic                    blocked;
        logic signed [SW-1:0]    sumv;
        logic signed [SW-1:0]    suma;
        logic signed [PSW-1:0]   dpn4;
        logic signed [PSW-1:0]   gh;
        logic signed [PSW-1:0]   gn;
        logic [SPC_BITS-1:0]     inv;
    } t_s0;

    typedef struct packed {
        logic                    blocked;
        logic signed [SW-1:0]    sumv;
        logic signed [PSW-1:0]   s4;
        logic                    pos;
        logic                    sat;
        logic [W-1:0]            dvs;
        logic [W-1:0]            rem;
        logic [QB-1:0]           quo;
        logic [SPC_BITS-1:0]     inv;
    } t_dv;

    typedef struct packed {
        logic                    blocked;
        logic signed [SW-1:0]    sumv;
        logic                    neg;
        logic                    sat;
        logic [MW-1:0]           mag;
        logic [DLO+SPC_BITS-1:0] plo;
        logic [DHI+SPC_BITS-1:0] phi;
    } t_m1;

    typedef struct packed {
        logic                    blocked;
        logic signed [SW-1:0]    sumv;
        logic                    neg;
        logic                    sat;
        logic [MW-1:0]           mag;
        logic [PW1-1:0]          p1;
    } t_m2;

    typedef struct packed {
        logic                              blocked;
        logic signed [SW-1:0]              sumv;
        logic                              neg;
        logic                              sat;
        logic [NA-1:0][NB-1:0][2*CK-1:0]   pp;
    } t_m3;

    typedef struct packed {
        logic                    blocked;
        logic signed [SW-1:0]    sumv;
        logic                    neg;
        logic                    sat;
        logic [NA-1:0][ROWW-1:0] row;
    } t_m4;

    typedef struct packed {
        logic                    blocked;
        logic signed [SW-1:0]    sumv;
        logic                    neg;
        logic                    sat;
        logic [PW-1:0]           prod;
    } t_m5;

    typedef struct packed {
        logic                    blocked;
        logic                    sat;
        logic signed [RW-1:0]    res2;
    } t_m6;

    // twice the cell-centred gradient, in pressure units
    function automatic logic signed [PSW-1:0] grad2(
        input logic lo_ok,
        input logic hi_ok,
        input logic signed [W-1:0] lo,
        input logic signed [W-1:0] mid,
        input logic signed [W-1:0] hi
    );
        logic signed [PSW-1:0] elo, emid, ehi, g;
        elo  = PSW'(lo);
        emid = PSW'(mid);
        ehi  = PSW'(hi);
        if (lo_ok && hi_ok) begin
            g = ehi - elo;
        end else if (hi_ok) begin
            g = (ehi - emid) <<< 1;
        end else if (lo_ok) begin
            g = (emid - elo) <<< 1;
        end else begin
            g = '0;
        end
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SPC_BITS-1:0] r_inv_x, r_inv_y, r_inv_z;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_x <= INV_RESET;
            r_inv_y <= INV_RESET;
            r_inv_z <= INV_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_INV_X: r_inv_x <= pwdata;
                REG_INV_Y: r_inv_y <= pwdata;
                REG_INV_Z: r_inv_z <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_INV_X: prdata = r_inv_x;
            REG_INV_Y: prdata = r_inv_y;
            REG_INV_Z: prdata = r_inv_z;
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: a slot advances when empty or when the next one does,
    // so bubbles close up and an item is taken while a result waits.
    // ------------------------------------------------------------------
    logic [NST-1:0] r_vld;
    logic [NST:0]   adv;

    always_comb begin
        adv[NST] = !i_out_stall;
        for (int k = NST - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_stall  = !adv[0];
    assign o_out_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: sums, gradients, spacing select
    // ------------------------------------------------------------------
    t_s0 r_s0, n_s0;

    always_comb begin
        n_s0.blocked = !i_in_item.fluid_flags[FLG_HERE] || !i_in_item.fluid_flags[FLG_NEXT];
        n_s0.sumv = SW'(i_in_item.vel_here) + SW'(i_in_item.vel_next);
        n_s0.suma = SW'(i_in_item.coef_here) + SW'(i_in_item.coef_next);
        n_s0.dpn4 = (PSW'(i_in_item.pres_next) - PSW'(i_in_item.pres_here)) <<< 2;
        n_s0.gh = grad2(i_in_item.fluid_flags[FLG_BEHIND], i_in_item.fluid_flags[FLG_NEXT],
                        i_in_item.pres_behind, i_in_item.pres_here, i_in_item.pres_next);
        n_s0.gn = grad2(i_in_item.fluid_flags[FLG_HERE], i_in_item.fluid_flags[FLG_BEYOND],
                        i_in_item.pres_here, i_in_item.pres_next, i_in_item.pres_beyond);
        case (i_in_item.axis)
            AXIS_X:  n_s0.inv = r_inv_x;
            AXIS_Y:  n_s0.inv = r_inv_y;
            default: n_s0.inv = r_inv_z;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_S0]) r_s0 <= n_s0;
    end

    // ------------------------------------------------------------------
    // Divider: slot DV0 sets up, then one quotient bit per slot, MSB first
    // ------------------------------------------------------------------
    t_dv r_dv [QB+1];
    t_dv n_dv0;

    always_comb begin
        n_dv0.blocked = r_s0.blocked;
        n_dv0.sumv    = r_s0.sumv;
        n_dv0.s4      = r_s0.dpn4 - r_s0.gh - r_s0.gn;
        n_dv0.pos     = (r_s0.suma > 0);
        n_dv0.sat     = n_dv0.pos && (64'(unsigned'(r_s0.suma)) <= SAT_LIM);
        n_dv0.dvs     = r_s0.suma[W-1:0];
        n_dv0.rem     = (n_dv0.pos && !n_dv0.sat) ? R0_VAL : '0;
        n_dv0.quo     = '0;
        n_dv0.inv     = r_s0.inv;
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_DV0]) r_dv[0] <= n_dv0;
    end

    for (genvar j = 1; j <= QB; j++) begin : g_div
        localparam int BI = QB - j;
        t_dv         n_st;
        logic [W:0]  r2;
        logic [W:0]  df;

        always_comb begin
            n_st = r_dv[j-1];
            r2   = {r_dv[j-1].rem, (BI == DIV_SH) ? 1'b1 : 1'b0};
            df   = r2 - {1'b0, r_dv[j-1].dvs};
            if (r2 >= {1'b0, r_dv[j-1].dvs}) begin
                n_st.rem     = df[W-1:0];
                n_st.quo[BI] = 1'b1;
            end else begin
                n_st.rem     = r2[W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[ST_DV0 + j]) r_dv[j] <= n_st;
        end
    end

    // ------------------------------------------------------------------
    // M1: pick reciprocal, magnitude of pressure term, split D * inv
    // ------------------------------------------------------------------
    t_m1          r_m1, n_m1;
    logic [QB-1:0] dval;

    always_comb begin
        if (!r_dv[QB].pos) begin
            dval = '0;
        end else if (r_dv[QB].sat) begin
            dval = D_MAX;
        end else begin
            dval = r_dv[QB].quo;
        end
        n_m1.blocked = r_dv[QB].blocked;
        n_m1.sumv    = r_dv[QB].sumv;
        n_m1.neg     = r_dv[QB].s4[PSW-1];
        n_m1.sat     = r_dv[QB].sat;
        n_m1.mag     = r_dv[QB].s4[PSW-1] ? MW'(-r_dv[QB].s4) : MW'(r_dv[QB].s4);
        n_m1.plo     = (DLO+SPC_BITS)'(dval[DLO-1:0]) * (DLO+SPC_BITS)'(r_dv[QB].inv);
        n_m1.phi     = (DHI+SPC_BITS)'(dval[QB-1:DLO]) * (DHI+SPC_BITS)'(r_dv[QB].inv);
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_M1]) r_m1 <= n_m1;
    end

    // M2: combine halves
    t_m2 r_m2, n_m2;

    always_comb begin
        n_m2.blocked = r_m1.blocked;
        n_m2.sumv    = r_m1.sumv;
        n_m2.neg     = r_m1.neg;
        n_m2.sat     = r_m1.sat;
        n_m2.mag     = r_m1.mag;
        n_m2.p1      = PW1'(r_m1.plo) + (PW1'(r_m1.phi) << DLO);
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_M2]) r_m2 <= n_m2;
    end

    // M3: chunk products of (D * inv) by magnitude
    t_m3               r_m3, n_m3;
    logic [NA*CK-1:0]  pa;
    logic [NB*CK-1:0]  mb;

    always_comb begin
        pa = (NA*CK)'(r_m2.p1);
        mb = (NB*CK)'(r_m2.mag);
        n_m3.blocked = r_m2.blocked;
        n_m3.sumv    = r_m2.sumv;
        n_m3.neg     = r_m2.neg;
        n_m3.sat     = r_m2.sat;
        for (int a = 0; a < NA; a++) begin
            for (int b = 0; b < NB; b++) begin
                n_m3.pp[a][b] = (2*CK)'(pa[a*CK +: CK]) * (2*CK)'(mb[b*CK +: CK]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_M3]) r_m3 <= n_m3;
    end

    // M4: row sums
    t_m4 r_m4, n_m4;

    always_comb begin
        n_m4.blocked = r_m3.blocked;
        n_m4.sumv    = r_m3.sumv;
        n_m4.neg     = r_m3.neg;
        n_m4.sat     = r_m3.sat;
        for (int a = 0; a < NA; a++) begin
            n_m4.row[a] = '0;
            for (int b = 0; b < NB; b++) begin
                n_m4.row[a] = n_m4.row[a] + (ROWW'(r_m3.pp[a][b]) << (b * CK));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_M4]) r_m4 <= n_m4;
    end

    // M5: full product
    t_m5 r_m5, n_m5;

    always_comb begin
        n_m5.blocked = r_m4.blocked;
        n_m5.sumv    = r_m4.sumv;
        n_m5.neg     = r_m4.neg;
        n_m5.sat     = r_m4.sat;
        n_m5.prod    = '0;
        for (int a = 0; a < NA; a++) begin
            n_m5.prod = n_m5.prod + (PW'(r_m4.row[a]) << (a * CK));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_M5]) r_m5 <= n_m5;
    end

    // M6: scale, cap, apply sign, subtract from velocity sum
    t_m6                  r_m6, n_m6;
    logic [VW-1:0]        vsc;
    logic [CW-1:0]        cm;
    logic signed [RW-1:0] corr;

    always_comb begin
        vsc  = r_m5.prod[PW-1:DIV_SH];
        cm   = (vsc > CAP) ? CW'(CAP) : CW'(vsc);
        corr = r_m5.neg ? -RW'(cm) : RW'(cm);
        n_m6.blocked = r_m5.blocked;
        n_m6.sat     = r_m5.sat;
        n_m6.res2    = RW'(r_m5.sumv) - corr;
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_M6]) r_m6 <= n_m6;
    end

    // Output: halve toward minus infinity, clip, force blocked faces
    t_out_item              r_out, n_out;
    logic signed [RW-2:0]   half;
    localparam logic signed [RW-2:0] RES_MAX = (RW-1)'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [RW-2:0] RES_MIN = -RES_MAX - (RW-1)'(1);

    always_comb begin
        half = r_m6.res2[RW-1:1];
        if (r_m6.blocked) begin
            n_out.face_velocity = '0;
            n_out.blocked       = 1'b1;
            n_out.saturated     = 1'b0;
        end else if (half > RES_MAX) begin
            n_out.face_velocity = RES_MAX[W-1:0];
            n_out.blocked       = 1'b0;
            n_out.saturated     = 1'b1;
        end else if (half < RES_MIN) begin
            n_out.face_velocity = RES_MIN[W-1:0];
            n_out.blocked       = 1'b0;
            n_out.saturated     = 1'b1;
        end else begin
            n_out.face_velocity = half[W-1:0];
            n_out.blocked       = 1'b0;
            n_out.saturated     = r_m6.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_OUT]) r_out <= n_out;
    end

    assign o_out_item = r_out;

`ifndef SYNTHESIS
    // a free output never back-pressures the input
    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled with output free");

    // a blocked face always carries a clean zero
    a_blocked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.blocked |->
            (o_out_item.face_velocity == '0) && !o_out_item.saturated)
        else $error("blocked face with nonzero result");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the Rhie-Chow face velocity unit.
module testbench;
    import rcfv_pkg::*;

    localparam int IDLE_PCT  = 28;
    localparam int DOG_LIMIT = 5000;
    localparam int DRAIN_PAD = WORD_BITS + 20;
    localparam longint WMAX  = (longint'(1) << (WORD_BITS - 1)) - 1;
    localparam longint WMIN  = -WMAX - 1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    rhie_chow_face_velocity_unit dut (.*);

    // predictor copy of the spacing registers
    logic [SPC_BITS-1:0] spc_x, spc_y, spc_z;
    t_out_item           pending_faces[$];
    int                  mismatches;
    int                  dog_cnt;
    bit                  calm;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // twice the cell-centred gradient in pressure units
    function automatic longint twice_grad(bit lo_ok, bit hi_ok, longint lo, longint mid,
                                          longint hi);
        if (lo_ok && hi_ok) return hi - lo;
        if (hi_ok) return 2 * (hi - mid);
        if (lo_ok) return 2 * (mid - lo);
        return 0;
    endfunction

    function automatic t_out_item face_velocity_of(t_in_item f);
        t_out_item       r;
        logic [SPC_BITS-1:0] inv;
        longint          sumv, suma, s4, corr2, res2, res;
        logic [127:0]    prod;
        longint unsigned d, mag, cm;
        bit              sat;
        r = '0;
        sat = 1'b0;
        d = 0;
        if (!f.fluid_flags[FLG_HERE] || !f.fluid_flags[FLG_NEXT]) begin
            r.blocked = 1'b1;
            return r;
        end
        inv = (f.axis == AXIS_X) ? spc_x : (f.axis == AXIS_Y) ? spc_y : spc_z;
        sumv = longint'(f.vel_here) + longint'(f.vel_next);
        suma = longint'(f.coef_here) + longint'(f.coef_next);
        if (suma > 0) begin
            d = (longint'(1) << (2 * FRAC_BITS + 1)) / suma;
            if (d > WMAX) begin
                d = WMAX;
                sat = 1'b1;
            end
        end
        s4 = 4 * (longint'(f.pres_next) - longint'(f.pres_here))
           - twice_grad(f.fluid_flags[FLG_BEHIND], 1'b1, f.pres_behind, f.pres_here,
                        f.pres_next)
           - twice_grad(1'b1, f.fluid_flags[FLG_BEYOND], f.pres_here, f.pres_next,
                        f.pres_beyond);
        mag = (s4 < 0) ? -s4 : s4;
        prod = (128'(d) * 128'(inv) * 128'(mag)) >> (2 * FRAC_BITS + 1);
        cm = (prod > (128'(1) << (WORD_BITS + 2))) ? (64'(1) << (WORD_BITS + 2))
                                                    : prod[63:0];
        corr2 = (s4 < 0) ? -longint'(cm) : longint'(cm);
        res2 = sumv - corr2;
        res = (res2 >= 0) ? res2 / 2 : -((-res2 + 1) / 2);
        if (res > WMAX) begin
            res = WMAX;
            sat = 1'b1;
        end
        if (res < WMIN) begin
            res = WMIN;
            sat = 1'b1;
        end
        r.face_velocity = res[WORD_BITS-1:0];
        r.saturated = sat;
        return r;
    endfunction

    // hold the item until it is taken, then log its expected result
    task automatic send_face(t_in_item f);
        bit taken;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= f;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        pending_faces.push_back(face_velocity_of(f));
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_faces.size() > 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // setup cycle, then access cycle; the register is written at the end of the access cycle
    task automatic write_spacing(logic [1:0] idx, logic [SPC_BITS-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INV_X: spc_x = val;
            REG_INV_Y: spc_y = val;
            default:   spc_z = val;
        endcase
    endtask

    function automatic logic [WORD_BITS-1:0] pick_word(int style);
        case (style)
            0: return $urandom();
            1: return WORD_BITS'($signed($urandom_range(2097152)) - 1048576);
            2: return WORD_BITS'($urandom_range(262144) + 1);
            default: begin
                case ($urandom_range(4))
                    0: return WORD_BITS'(WMAX);
                    1: return WORD_BITS'(WMIN);
                    2: return '0;
                    3: return WORD_BITS'(1);
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    function automatic t_in_item random_face();
        t_in_item f;
        int       style;
        style = ($urandom_range(99) < 15) ? 0 : ($urandom_range(99) < 10) ? 3 : 1;
        f.axis        = AXIS_BITS'($urandom_range(3));
        f.vel_here    = pick_word(style);
        f.vel_next    = pick_word(style);
        // mostly positive coefficients so the correction path is exercised
        f.coef_here   = (style == 1) ? pick_word(2) : pick_word(style);
        f.coef_next   = (style == 1) ? pick_word(2) : pick_word(style);
        f.pres_behind = pick_word(style);
        f.pres_here   = pick_word(style);
        f.pres_next   = pick_word(style);
        f.pres_beyond = pick_word(style);
        // most faces open, some blocked
        f.fluid_flags = FLAG_BITS'($urandom_range(15));
        if ($urandom_range(99) < 75) f.fluid_flags[2:1] = 2'b11;
        return f;
    endfunction

    function automatic t_in_item open_face(logic [3:0] flags, logic [1:0] axis);
        t_in_item f;
        f.axis        = axis;
        f.vel_here    = 32'sh0001_0000;
        f.vel_next    = 32'sh0003_0000;
        f.coef_here   = 32'sh0002_0000;
        f.coef_next   = 32'sh0002_0000;
        f.pres_behind = 32'sh0001_0000;
        f.pres_here   = 32'sh0004_0000;
        f.pres_next   = 32'sh0009_0000;
        f.pres_beyond = 32'sh0010_0000;
        f.fluid_flags = flags;
        return f;
    endfunction

    // every flag pattern, every axis code, word extremes, degenerate coefficients
    task automatic test_directed;
        t_in_item f;
        for (int k = 0; k < 16; k++) send_face(open_face(4'(k), 2'(k)));
        f = open_face(4'hF, AXIS_X);
        f.coef_here = 1;
        f.coef_next = 0;
        send_face(f);
        f.coef_here = 0;
        send_face(f);
        f.coef_here = -5;
        send_face(f);
        f = open_face(4'hF, AXIS_Y);
        f.vel_here = WORD_BITS'(WMAX);
        f.vel_next = WORD_BITS'(WMAX);
        f.pres_next = WORD_BITS'(WMAX);
        f.pres_here = WORD_BITS'(WMIN);
        f.coef_here = 1;
        f.coef_next = 1;
        send_face(f);
        f.vel_here = WORD_BITS'(WMIN);
        f.vel_next = WORD_BITS'(WMIN);
        f.pres_next = WORD_BITS'(WMIN);
        f.pres_here = WORD_BITS'(WMAX);
        send_face(f);
        f.coef_here = WORD_BITS'(WMAX);
        f.coef_next = WORD_BITS'(WMAX);
        send_face(f);
        drain();
    endtask

    // sweep spacing settings including the extremes and zero
    task automatic test_spacing;
        logic [SPC_BITS-1:0] vals[6];
        vals = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'h0001_0000, 32'h0000_4000, 32'h0100_0000};
        for (int k = 0; k < 6; k++) begin
            write_spacing(REG_INV_X, vals[k]);
            write_spacing(REG_INV_Y, vals[(k + 2) % 6]);
            write_spacing(REG_INV_Z, (k == 5) ? $urandom() : vals[(k + 4) % 6]);
            repeat (60) send_face(random_face());
            drain();
        end
    endtask

    task automatic test_random;
        write_spacing(REG_INV_X, 32'h0001_0000);
        write_spacing(REG_INV_Y, 32'h0002_0000);
        write_spacing(REG_INV_Z, 32'h0000_8000);
        for (int n = 0; n < 1300; n++) begin
            calm = (n >= 500 && n < 700);
            send_face(random_face());
        end
        calm = 1'b0;
        drain();
    endtask

    // result stall: random except during the calm stretch
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // compare each taken result with the oldest expectation
    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_faces.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_item);
            end else begin
                want = pending_faces.pop_front();
                if (want.face_velocity !== o_out_item.face_velocity ||
                    want.blocked !== o_out_item.blocked ||
                    want.saturated !== o_out_item.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected vel %h blk %b sat %b, got %h %b %b",
                                 want.face_velocity, want.blocked, want.saturated,
                                 o_out_item.face_velocity, o_out_item.blocked,
                                 o_out_item.saturated);
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            dog_cnt = 0;
        else
            dog_cnt++;
        if (dog_cnt >= DOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        mismatches  = 0;
        dog_cnt     = 0;
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        spc_x       = INV_RESET;
        spc_y       = INV_RESET;
        spc_z       = INV_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_spacing();
        test_random();
        if (mismatches == 0 && pending_faces.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
